// ===== hdl/teq_pkg.sv =====
// teq_pkg: types, constants and pointer helpers for the timed event queue.
// Used by every module of the block; no dependencies.
`default_nettype none

package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W      = 32;
    localparam int KIND_W      = 2;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE = 3'd0,
        CMD_STEP     = 3'd1,
        CMD_RUN      = 3'd2,
        CMD_READ     = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOT_DUE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCH_CMP,
        S_SCH_PUT,
        S_STEP_CHK,
        S_RUN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        t_entry           entry;
    } t_wr_req;

    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              le;
        logic              eq;
    } t_cmp_res;

    // (p + k) modulo QUEUE_DEPTH, both operands below QUEUE_DEPTH
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, k};
        if (s >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (PTR_W + 1)'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/teq_store.sv =====
// teq_store: circular event store, one write and one registered read port.
// Depends on teq_pkg.
`default_nettype none

module teq_store (
    input  wire logic                    i_clk,
    input  wire teq_pkg::t_wr_req        i_wr,
    input  wire logic [teq_pkg::PTR_W-1:0] i_rd_addr,
    output teq_pkg::t_entry              o_rd_data
);
    import teq_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/teq_cmp.sv =====
// teq_cmp: shared distance unit, (a - b) mod 2^32 compared against a limit.
// Depends on teq_pkg.
`default_nettype none

module teq_cmp (
    input  wire logic [teq_pkg::TIME_W-1:0] i_a,
    input  wire logic [teq_pkg::TIME_W-1:0] i_b,
    input  wire logic [teq_pkg::TIME_W-1:0] i_lim,
    output teq_pkg::t_cmp_res               o_res
);
    import teq_pkg::*;

    logic [TIME_W-1:0] diff;

    assign diff       = i_a - i_b;
    assign o_res.diff = diff;
    assign o_res.le   = (diff <= i_lim);
    assign o_res.eq   = (diff == '0);

endmodule

`default_nettype wire

// ===== hdl/teq_ctrl.sv =====
// teq_ctrl: command sequencer, queue pointers, simulated clock, output register.
// Depends on teq_pkg; drives teq_store and teq_cmp.
`default_nettype none

module teq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [teq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [teq_pkg::TIME_W-1:0]    i_delay,
    input  wire logic [teq_pkg::KIND_W-1:0]    i_event_kind,
    input  wire logic [teq_pkg::DATA_W-1:0]    i_event_payload,
    input  wire logic [teq_pkg::TIME_W-1:0]    i_target_time,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [teq_pkg::STATUS_W-1:0]       o_status,
    output logic [teq_pkg::KIND_W-1:0]         o_fired_kind,
    output logic [teq_pkg::DATA_W-1:0]         o_fired_payload,
    output logic [teq_pkg::TIME_W-1:0]         o_fired_time,
    output logic [teq_pkg::TIME_W-1:0]         o_now_time,
    output logic [teq_pkg::COUNT_OUT_W-1:0]    o_retired_count,
    output logic [teq_pkg::COUNT_OUT_W-1:0]    o_queued_count,
    output teq_pkg::t_wr_req                   o_wr,
    output logic [teq_pkg::PTR_W-1:0]          o_rd_addr,
    input  wire teq_pkg::t_entry               i_rd_data,
    output logic [teq_pkg::TIME_W-1:0]         o_cmp_a,
    output logic [teq_pkg::TIME_W-1:0]         o_cmp_b,
    output logic [teq_pkg::TIME_W-1:0]         o_cmp_lim,
    input  wire teq_pkg::t_cmp_res             i_cmp
);
    import teq_pkg::*;

    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_occ,     n_occ;
    logic [PTR_W-1:0]    r_head,    n_head;
    logic [PTR_W-1:0]    r_idx,     n_idx;
    logic [TIME_W-1:0]   r_now,     n_now;
    logic [TIME_W-1:0]   r_delay,   n_delay;
    logic [TIME_W-1:0]   r_span,    n_span;
    logic [TIME_W-1:0]   r_target,  n_target;
    t_entry              r_new,     n_new;
    t_status             r_status,  n_status;
    t_entry              r_fired,   n_fired;
    logic [CNT_W-1:0]    r_retired, n_retired;

    logic                r_ov,      n_ov;
    t_status             r_o_status,  n_o_status;
    t_entry              r_o_fired,   n_o_fired;
    logic [TIME_W-1:0]   r_o_now,     n_o_now;
    logic [CNT_W-1:0]    r_o_retired, n_o_retired;
    logic [CNT_W-1:0]    r_o_occ,     n_o_occ;

    logic                accept;
    logic [PTR_W-1:0]    tail_idx;
    logic [PTR_W-1:0]    one_idx;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign tail_idx = (r_occ != '0) ? PTR_W'(r_occ - 1'b1) : '0;
    assign one_idx  = PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_head  <= '0;
            r_now   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_head  <= n_head;
            r_now   <= n_now;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_delay     <= n_delay;
        r_span      <= n_span;
        r_target    <= n_target;
        r_new       <= n_new;
        r_status    <= n_status;
        r_fired     <= n_fired;
        r_retired   <= n_retired;
        r_o_status  <= n_o_status;
        r_o_fired   <= n_o_fired;
        r_o_now     <= n_o_now;
        r_o_retired <= n_o_retired;
        r_o_occ     <= n_o_occ;
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_head      = r_head;
        n_idx       = r_idx;
        n_now       = r_now;
        n_delay     = r_delay;
        n_span      = r_span;
        n_target    = r_target;
        n_new       = r_new;
        n_status    = r_status;
        n_fired     = r_fired;
        n_retired   = r_retired;
        n_ov        = r_ov;
        n_o_status  = r_o_status;
        n_o_fired   = r_o_fired;
        n_o_now     = r_o_now;
        n_o_retired = r_o_retired;
        n_o_occ     = r_o_occ;

        o_wr        = '0;
        o_rd_addr   = r_head;
        o_cmp_a     = i_rd_data.tstamp;
        o_cmp_b     = r_now;
        o_cmp_lim   = r_span;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_cmp_a = i_target_time;
                if (t_cmd'(i_command) == CMD_SCHEDULE) begin
                    o_rd_addr = ptr_add(r_head, tail_idx);
                end
                if (accept) begin
                    n_status  = ST_OK;
                    n_fired   = '0;
                    n_retired = '0;
                    n_delay   = i_delay;
                    n_target  = i_target_time;
                    n_new     = '{tstamp: r_now + i_delay, kind: i_event_kind,
                                  data: i_event_payload};
                    n_state   = S_DONE;
                    case (t_cmd'(i_command))
                        CMD_SCHEDULE: begin
                            if (r_occ >= CNT_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_occ == '0) begin
                                o_wr.en    = 1'b1;
                                o_wr.addr  = r_head;
                                o_wr.entry = n_new;
                                n_occ      = r_occ + 1'b1;
                            end else begin
                                n_idx   = tail_idx;
                                n_state = S_SCH_CMP;
                            end
                        end
                        CMD_STEP: begin
                            if (r_occ == '0) begin
                                n_status = ST_NOT_DUE;
                            end else begin
                                n_state = S_STEP_CHK;
                            end
                        end
                        CMD_RUN: begin
                            n_span = i_cmp.diff;
                            if (r_occ == '0) begin
                                n_now = i_target_time;
                            end else begin
                                n_state = S_RUN_CHK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_occ  = '0;
                            n_now  = '0;
                            n_head = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // walk from the tail toward the head, moving later events back one slot
            S_SCH_CMP: begin
                o_cmp_lim  = r_delay;
                o_rd_addr  = ptr_add(r_head, (r_idx != '0) ? r_idx - 1'b1 : '0);
                o_wr.en    = 1'b1;
                o_wr.addr  = ptr_add(r_head, r_idx + 1'b1);
                o_wr.entry = i_cmp.le ? r_new : i_rd_data;
                if (i_cmp.le) begin
                    n_occ   = r_occ + 1'b1;
                    n_state = S_DONE;
                end else if (r_idx == '0) begin
                    o_wr.en = 1'b1;
                    n_state = S_SCH_PUT;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end

            S_SCH_PUT: begin
                o_wr.en    = 1'b1;
                o_wr.addr  = r_head;
                o_wr.entry = r_new;
                n_occ      = r_occ + 1'b1;
                n_state    = S_DONE;
            end

            S_STEP_CHK: begin
                if (i_cmp.eq) begin
                    n_fired = i_rd_data;
                    n_head  = ptr_add(r_head, one_idx);
                    n_occ   = r_occ - 1'b1;
                end else begin
                    n_status = ST_NOT_DUE;
                end
                n_state = S_DONE;
            end

            // one retired event per cycle; the read of the next head overlaps the check
            S_RUN_CHK: begin
                o_rd_addr = ptr_add(r_head, one_idx);
                if ((r_occ != '0) && i_cmp.le) begin
                    n_head    = ptr_add(r_head, one_idx);
                    n_occ     = r_occ - 1'b1;
                    n_retired = r_retired + 1'b1;
                end else begin
                    n_now   = r_target;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov        = 1'b1;
                    n_o_status  = r_status;
                    n_o_fired   = r_fired;
                    n_o_now     = r_now;
                    n_o_retired = r_retired;
                    n_o_occ     = r_occ;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_fired_kind    = r_o_fired.kind;
    assign o_fired_payload = r_o_fired.data;
    assign o_fired_time    = r_o_fired.tstamp;
    assign o_now_time      = r_o_now;
    assign o_retired_count = COUNT_OUT_W'(r_o_retired);
    assign o_queued_count  = COUNT_OUT_W'(r_o_occ);

endmodule

`default_nettype wire

// ===== hdl/timed_event_queue.sv =====
// timed_event_queue: top level of the time-ordered event queue.
// Depends on teq_pkg, teq_store, teq_cmp and teq_ctrl.
//
// A bounded queue of timed events kept sorted by distance ahead of a 32-bit
// simulated clock that wraps. Commands: 0 schedule (insert at now + delay,
// behind equal times), 1 step (pop the head if it is due now), 2 run until
// target (retire everything due up to the target, then set now to it),
// 3 read time, 4 clear; codes 5 to 7 behave as read time. Events sit in a
// circular store with one read and one write port, and one subtract/compare
// unit is reused by a sequencer, so a command is taken only when the previous
// one is finished. Read time, clear and the full/empty cases go straight to
// the result, step checks the head once, schedule moves back each queued
// event that sorts after the new one (one store move per cycle), and run
// until target checks and retires the due events one after another. A
// finished result waits in an output register, so the next transaction may
// be accepted while it is still pending.
`default_nettype none

module timed_event_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [teq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [teq_pkg::TIME_W-1:0]    i_delay,
    input  wire logic [teq_pkg::KIND_W-1:0]    i_event_kind,
    input  wire logic [teq_pkg::DATA_W-1:0]    i_event_payload,
    input  wire logic [teq_pkg::TIME_W-1:0]    i_target_time,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [teq_pkg::STATUS_W-1:0]       o_status,
    output logic [teq_pkg::KIND_W-1:0]         o_fired_kind,
    output logic [teq_pkg::DATA_W-1:0]         o_fired_payload,
    output logic [teq_pkg::TIME_W-1:0]         o_fired_time,
    output logic [teq_pkg::TIME_W-1:0]         o_now_time,
    output logic [teq_pkg::COUNT_OUT_W-1:0]    o_retired_count,
    output logic [teq_pkg::COUNT_OUT_W-1:0]    o_queued_count
);
    import teq_pkg::*;

    t_wr_req            wr;
    logic [PTR_W-1:0]   rd_addr;
    t_entry             rd_data;
    logic [TIME_W-1:0]  cmp_a;
    logic [TIME_W-1:0]  cmp_b;
    logic [TIME_W-1:0]  cmp_lim;
    t_cmp_res           cmp_res;

    teq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    teq_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .i_lim (cmp_lim),
        .o_res (cmp_res)
    );

    teq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_delay         (i_delay),
        .i_event_kind    (i_event_kind),
        .i_event_payload (i_event_payload),
        .i_target_time   (i_target_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_fired_kind    (o_fired_kind),
        .o_fired_payload (o_fired_payload),
        .o_fired_time    (o_fired_time),
        .o_now_time      (o_now_time),
        .o_retired_count (o_retired_count),
        .o_queued_count  (o_queued_count),
        .o_wr            (wr),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_cmp_a         (cmp_a),
        .o_cmp_b         (cmp_b),
        .o_cmp_lim       (cmp_lim),
        .i_cmp           (cmp_res)
    );

    // a full report must come with a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |->
            (o_queued_count == COUNT_OUT_W'(QUEUE_DEPTH)))
        else $error("full status with queue not full");

    // only a fired event carries fired fields, and run-until never fires one
    a_fired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status != ST_OK) || (o_retired_count != '0))) |->
            ((o_fired_time == '0) && (o_fired_payload == '0) && (o_fired_kind == '0)))
        else $error("fired fields set without a fired event");

    // the store is written only while a transaction is in progress
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && o_in_ready) |-> (i_in_valid && (i_command == CMD_SCHEDULE)))
        else $error("store write while idle");

    // the queue never reports more than its depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queued_count <= COUNT_OUT_W'(QUEUE_DEPTH)))
        else $error("queued count beyond depth");

endmodule

`default_nettype wire
